@@ hdl/shbt_pkg.sv @@
// Package for the spatial hash bucket table: field widths, opcodes,
// register indexes, reset values and the sequencer state types.
// No dependencies; every other file imports it.
package shbt_pkg;

    // Field widths
    localparam int ID_W       = 16;
    localparam int POS_W      = 32;
    localparam int CELL_W     = 16;
    localparam int BKT_OUT_W  = 10;
    localparam int USED_OUT_W = 11;
    localparam int PRIME_W    = 31;
    localparam int NCELL_W    = 11;
    localparam int ENTRY_W    = ID_W + 3 * CELL_W;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Remainder datapath: remainder below the modulus, sum of three terms
    localparam int REM_W = NCELL_W;
    localparam int ACC_W = 14;

    // Opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_INV_CELL  = 3'd0;
    localparam logic [2:0] REG_PRIME_X   = 3'd1;
    localparam logic [2:0] REG_PRIME_Y   = 3'd2;
    localparam logic [2:0] REG_PRIME_Z   = 3'd3;
    localparam logic [2:0] REG_NUM_CELLS = 3'd4;

    // Register reset values
    localparam logic [31:0]        RST_INV_CELL  = 32'd65536;
    localparam logic [PRIME_W-1:0] RST_PRIME_X   = 31'd73856093;
    localparam logic [PRIME_W-1:0] RST_PRIME_Y   = 31'd19349663;
    localparam logic [PRIME_W-1:0] RST_PRIME_Z   = 31'd83492791;
    localparam logic [NCELL_W-1:0] RST_NUM_CELLS = 11'd1024;

    // Hash unit sequencer
    typedef enum logic [2:0] {
        H_IDLE,
        H_CMUL,
        H_CSAT,
        H_HMUL,
        H_RSET,
        H_REM,
        H_ACC,
        H_FOLD
    } t_hash_state;

    // Table controller sequencer
    typedef enum logic [3:0] {
        C_INIT,
        C_IDLE,
        C_HASH,
        C_LOOK,
        C_DECIDE,
        C_RD_ADDR,
        C_RD_OUT,
        C_CLR_ADDR,
        C_CLR_WR
    } t_ctl_state;

    // Request from controller to hash unit
    typedef struct packed {
        logic go;
        logic conv;
    } t_hash_req;

endpackage

@@ hdl/spatial_hash_bucket_table_top.sv @@
// Spatial hash bucket table: command sequencer, bucket memories and
// configuration registers. Depends on shbt_pkg and shbt_hash.
// An insert converts the position to cells first; insert, query and read then hash each axis
//   (multiply, 32-step remainder) and fold the sum into the table range.
// A filled read gives its entries one by one; clear walks the list of used buckets. One
//   command at a time; the next may be transferred in the cycle of the last result.
//   Results are a one-cycle strobe.
// Reset: synchronous; afterwards the fill memory is swept to zero with busy high.
module spatial_hash_bucket_table_top
    import shbt_pkg::*;
#(
    parameter int NUM_BUCKETS  = 1024,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_opcode,
    input  logic [ID_W-1:0]          i_body_id,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic signed [CELL_W-1:0] i_cell_x,
    input  logic signed [CELL_W-1:0] i_cell_y,
    input  logic signed [CELL_W-1:0] i_cell_z,
    output logic                     o_valid,
    output logic                     o_status,
    output logic [BKT_OUT_W-1:0]     o_bucket,
    output logic                     o_is_empty,
    output logic                     o_entry_valid,
    output logic [ID_W-1:0]          o_entry_id,
    output logic signed [CELL_W-1:0] o_entry_cell_x,
    output logic signed [CELL_W-1:0] o_entry_cell_y,
    output logic signed [CELL_W-1:0] o_entry_cell_z,
    output logic [USED_OUT_W-1:0]    o_used_cells,
    output logic                     o_last,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int IW  = $clog2(NUM_BUCKETS);
    localparam int FW  = $clog2(BUCKET_DEPTH + 1);
    localparam int UW  = $clog2(NUM_BUCKETS + 1);
    localparam int CW  = (UW > FW) ? UW : FW;
    localparam int SAW = $clog2(NUM_BUCKETS * BUCKET_DEPTH);
    localparam int SD  = NUM_BUCKETS * BUCKET_DEPTH;

    typedef struct packed {
        logic                     status;
        logic [BKT_OUT_W-1:0]     bucket;
        logic                     is_empty;
        logic                     entry_valid;
        logic [ID_W-1:0]          entry_id;
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
        logic signed [CELL_W-1:0] cz;
        logic                     last;
    } t_result;

    // Configuration registers
    logic [31:0]        r_inv_cell_size;
    logic [PRIME_W-1:0] r_prime_x, r_prime_y, r_prime_z;
    logic [NCELL_W-1:0] r_num_cells;
    logic               cfg_we;
    logic [2:0]         cfg_idx;

    // Sequencer and captured command
    t_ctl_state               r_state, n_state;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [UW-1:0]            r_used_total, n_used_total;
    t_hash_req                r_hreq, n_hreq;
    t_result                  r_res, n_res;
    logic                     r_valid, n_valid;
    logic [1:0]               r_op;
    logic [ID_W-1:0]          r_id;
    logic signed [POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic signed [CELL_W-1:0] r_qx, r_qy, r_qz;
    logic                     accept;

    // Hash unit results
    logic                     hash_done;
    logic [IW-1:0]            hash_bucket;
    logic signed [CELL_W-1:0] hash_cx, hash_cy, hash_cz;
    logic [31:0]              bkt_ext;
    logic [31:0]              slot_base;
    logic [31:0]              used_ext;

    // Memories
    logic [FW-1:0]      fill_mem [NUM_BUCKETS];
    logic [IW-1:0]      ul_mem [NUM_BUCKETS];
    logic [ENTRY_W-1:0] store_mem [SD];

    logic               fill_we, fill_re;
    logic [IW-1:0]      fill_waddr, fill_raddr;
    logic [FW-1:0]      fill_wdata, r_fill_q;
    logic               ul_we;
    logic [IW-1:0]      ul_waddr, ul_raddr, r_ul_q;
    logic               store_we;
    logic [SAW-1:0]     store_waddr, store_raddr;
    logic [ENTRY_W-1:0] store_wdata, r_store_q;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_we  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell_size <= RST_INV_CELL;
            r_prime_x       <= RST_PRIME_X;
            r_prime_y       <= RST_PRIME_Y;
            r_prime_z       <= RST_PRIME_Z;
            r_num_cells     <= RST_NUM_CELLS;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_INV_CELL:  r_inv_cell_size <= pwdata;
                REG_PRIME_X:   r_prime_x       <= pwdata[PRIME_W-1:0];
                REG_PRIME_Y:   r_prime_y       <= pwdata[PRIME_W-1:0];
                REG_PRIME_Z:   r_prime_z       <= pwdata[PRIME_W-1:0];
                REG_NUM_CELLS: r_num_cells     <= pwdata[NCELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_INV_CELL:  prdata = r_inv_cell_size;
            REG_PRIME_X:   prdata = {1'b0, r_prime_x};
            REG_PRIME_Y:   prdata = {1'b0, r_prime_y};
            REG_PRIME_Z:   prdata = {1'b0, r_prime_z};
            REG_NUM_CELLS: prdata = APB_DW'(r_num_cells);
            default:       prdata = '0;
        endcase
    end

    // Hash unit
    shbt_hash #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_hash (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (r_hreq),
        .i_pos_x         (r_pos_x),
        .i_pos_y         (r_pos_y),
        .i_pos_z         (r_pos_z),
        .i_cell_x        (r_qx),
        .i_cell_y        (r_qy),
        .i_cell_z        (r_qz),
        .i_inv_cell_size (r_inv_cell_size),
        .i_prime_x       (r_prime_x),
        .i_prime_y       (r_prime_y),
        .i_prime_z       (r_prime_z),
        .i_num_cells     (r_num_cells),
        .o_done          (hash_done),
        .o_bucket        (hash_bucket),
        .o_cell_x        (hash_cx),
        .o_cell_y        (hash_cy),
        .o_cell_z        (hash_cz)
    );

    assign busy      = (r_state != C_IDLE);
    assign accept    = start & ~busy;
    assign bkt_ext   = 32'(hash_bucket);
    assign slot_base = 32'(32'(hash_bucket) * BUCKET_DEPTH);

    // Command sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_used_total = r_used_total;
        n_hreq       = '0;
        n_res        = r_res;
        n_valid      = 1'b0;
        fill_we      = 1'b0;
        fill_re      = 1'b0;
        fill_waddr   = hash_bucket;
        fill_raddr   = hash_bucket;
        fill_wdata   = '0;
        ul_we        = 1'b0;
        ul_waddr     = r_used_total[IW-1:0];
        ul_raddr     = r_cnt[IW-1:0];
        store_we     = 1'b0;
        store_waddr  = SAW'(slot_base + 32'(r_fill_q));
        store_raddr  = SAW'(slot_base + 32'(r_cnt));
        store_wdata  = {r_id, hash_cx, hash_cy, hash_cz};
        case (r_state)
            C_INIT: begin
                // sweep fill counts to zero after reset
                fill_we    = 1'b1;
                fill_waddr = r_cnt[IW-1:0];
                if (r_cnt == CW'(NUM_BUCKETS - 1)) begin
                    n_cnt   = '0;
                    n_state = C_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            C_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (i_opcode == OP_CLEAR) begin
                        n_state = C_CLR_ADDR;
                    end else begin
                        n_hreq.go   = 1'b1;
                        n_hreq.conv = (i_opcode == OP_INSERT);
                        n_state     = C_HASH;
                    end
                end
            end
            C_HASH: begin
                if (hash_done) begin
                    n_state = C_LOOK;
                end
            end
            C_LOOK: begin
                fill_re = 1'b1;
                n_state = C_DECIDE;
            end
            C_DECIDE: begin
                n_res        = '0;
                n_res.bucket = bkt_ext[BKT_OUT_W-1:0];
                n_res.last   = 1'b1;
                if (r_op == OP_INSERT) begin
                    n_valid = 1'b1;
                    n_state = C_IDLE;
                    if (r_fill_q == FW'(BUCKET_DEPTH)) begin
                        // bucket full: entry dropped
                        n_res.status = 1'b1;
                    end else begin
                        store_we   = 1'b1;
                        fill_we    = 1'b1;
                        fill_wdata = r_fill_q + FW'(1);
                        if (r_fill_q == '0) begin
                            ul_we        = 1'b1;
                            n_used_total = r_used_total + UW'(1);
                        end
                        n_res.entry_valid = 1'b1;
                        n_res.entry_id    = r_id;
                        n_res.cx          = hash_cx;
                        n_res.cy          = hash_cy;
                        n_res.cz          = hash_cz;
                    end
                end else if (r_op == OP_QUERY || r_fill_q == '0) begin
                    n_res.is_empty = (r_fill_q == '0);
                    n_valid        = 1'b1;
                    n_state        = C_IDLE;
                end else begin
                    n_cnt   = '0;
                    n_state = C_RD_ADDR;
                end
            end
            C_RD_ADDR: begin
                n_state = C_RD_OUT;
            end
            C_RD_OUT: begin
                n_res             = '0;
                n_res.bucket      = bkt_ext[BKT_OUT_W-1:0];
                n_res.entry_valid = 1'b1;
                {n_res.entry_id, n_res.cx, n_res.cy, n_res.cz} = r_store_q;
                n_res.last        = (CW'(r_cnt + CW'(1)) == CW'(r_fill_q));
                n_valid           = 1'b1;
                n_cnt             = r_cnt + CW'(1);
                n_state           = n_res.last ? C_IDLE : C_RD_ADDR;
            end
            C_CLR_ADDR: begin
                if (r_cnt == CW'(r_used_total)) begin
                    n_res        = '0;
                    n_res.last   = 1'b1;
                    n_valid      = 1'b1;
                    n_used_total = '0;
                    n_state      = C_IDLE;
                end else begin
                    n_state = C_CLR_WR;
                end
            end
            C_CLR_WR: begin
                fill_we    = 1'b1;
                fill_waddr = r_ul_q;
                n_cnt      = r_cnt + CW'(1);
                n_state    = C_CLR_ADDR;
            end
            default: n_state = C_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= C_INIT;
            r_cnt        <= '0;
            r_used_total <= '0;
            r_hreq       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_used_total <= n_used_total;
            r_hreq       <= n_hreq;
            r_valid      <= n_valid;
        end
    end

    // Result and command payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_op    <= i_opcode;
            r_id    <= i_body_id;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
            r_qx    <= i_cell_x;
            r_qy    <= i_cell_y;
            r_qz    <= i_cell_z;
        end
    end

    // Fill count memory
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re) begin
            r_fill_q <= fill_mem[fill_raddr];
        end
    end

    // Used bucket list
    always_ff @(posedge i_clk) begin
        if (ul_we) begin
            ul_mem[ul_waddr] <= hash_bucket;
        end
        r_ul_q <= ul_mem[ul_raddr];
    end

    // Entry store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store_mem[store_waddr] <= store_wdata;
        end
        r_store_q <= store_mem[store_raddr];
    end

    // Result ports
    assign used_ext       = 32'(r_used_total);
    assign o_valid        = r_valid;
    assign o_status       = r_res.status;
    assign o_bucket       = r_res.bucket;
    assign o_is_empty     = r_res.is_empty;
    assign o_entry_valid  = r_res.entry_valid;
    assign o_entry_id     = r_res.entry_id;
    assign o_entry_cell_x = r_res.cx;
    assign o_entry_cell_y = r_res.cy;
    assign o_entry_cell_z = r_res.cz;
    assign o_used_cells   = used_ext[USED_OUT_W-1:0];
    assign o_last         = r_res.last;

endmodule

@@ hdl/shbt_hash.sv @@
// Hash unit: position to cell conversion and bucket hash, built on one
// shared 32x32 multiplier and a one-bit-per-cycle remainder step.
// Depends on shbt_pkg.
module shbt_hash
    import shbt_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_hash_req                i_req,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic signed [CELL_W-1:0] i_cell_x,
    input  logic signed [CELL_W-1:0] i_cell_y,
    input  logic signed [CELL_W-1:0] i_cell_z,
    input  logic [31:0]              i_inv_cell_size,
    input  logic [PRIME_W-1:0]       i_prime_x,
    input  logic [PRIME_W-1:0]       i_prime_y,
    input  logic [PRIME_W-1:0]       i_prime_z,
    input  logic [NCELL_W-1:0]       i_num_cells,
    output logic                     o_done,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_bucket,
    output logic signed [CELL_W-1:0] o_cell_x,
    output logic signed [CELL_W-1:0] o_cell_y,
    output logic signed [CELL_W-1:0] o_cell_z
);

    localparam int IW = $clog2(NUM_BUCKETS);

    t_hash_state              r_state, n_state;
    logic [1:0]               r_axis, n_axis;
    logic [63:0]              r_prod, n_prod;
    logic                     r_neg, n_neg;
    logic [31:0]              r_mag, n_mag;
    logic [4:0]               r_bit, n_bit;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [CELL_W-1:0] r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic                     r_done, n_done;

    logic [NCELL_W-1:0]       mod_n;
    logic signed [POS_W-1:0]  pos_sel;
    logic [31:0]              pos_mag;
    logic [PRIME_W-1:0]       prime_sel;
    logic signed [CELL_W-1:0] cell_sel;
    logic signed [CELL_W-1:0] cell_sat;
    logic [31:0]              quot;
    logic [31:0]              mul_a, mul_b;
    logic [63:0]              mul_p;
    logic [REM_W:0]           rem_t;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  mod_s;
    logic [31:0]              prod_lo;
    logic [31:0]              acc_ext;

    // Effective modulus: zero acts as one, clamp to the table size
    always_comb begin
        if (i_num_cells == '0) begin
            mod_n = NCELL_W'(1);
        end else if (32'(i_num_cells) > NUM_BUCKETS) begin
            mod_n = NCELL_W'(NUM_BUCKETS);
        end else begin
            mod_n = i_num_cells;
        end
    end

    // Per-axis operand selection
    always_comb begin
        case (r_axis)
            2'd0: begin
                pos_sel   = i_pos_x;
                prime_sel = i_prime_x;
                cell_sel  = r_cx;
            end
            2'd1: begin
                pos_sel   = i_pos_y;
                prime_sel = i_prime_y;
                cell_sel  = r_cy;
            end
            default: begin
                pos_sel   = i_pos_z;
                prime_sel = i_prime_z;
                cell_sel  = r_cz;
            end
        endcase
    end

    assign pos_mag = pos_sel[POS_W-1] ? (~pos_sel + 32'd1) : pos_sel;

    // Shared multiplier: cell conversion or hash product
    always_comb begin
        if (r_state == H_CMUL) begin
            mul_a = pos_mag;
            mul_b = i_inv_cell_size;
        end else begin
            mul_a = 32'(cell_sel);
            mul_b = {1'b0, prime_sel};
        end
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Truncate toward zero and saturate to 16 bits
    assign quot = r_prod[63:32];
    always_comb begin
        if (r_neg) begin
            cell_sat = (quot > 32'd32768) ? -16'sd32768 : -$signed(quot[CELL_W-1:0]);
        end else begin
            cell_sat = (quot > 32'd32767) ? 16'sd32767 : $signed(quot[CELL_W-1:0]);
        end
    end

    // Remainder step and signed term
    always_comb begin
        rem_t = {r_rem, r_mag[31]};
        if (rem_t >= {1'b0, mod_n}) begin
            rem_t = rem_t - {1'b0, mod_n};
        end
    end
    assign term    = r_neg ? -$signed(ACC_W'(r_rem)) : $signed(ACC_W'(r_rem));
    assign mod_s   = $signed(ACC_W'(mod_n));
    assign prod_lo = r_prod[31:0];

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_prod  = r_prod;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cz    = r_cz;
        n_done  = 1'b0;
        case (r_state)
            H_IDLE: begin
                if (i_req.go) begin
                    n_axis = 2'd0;
                    n_acc  = '0;
                    if (i_req.conv) begin
                        n_state = H_CMUL;
                    end else begin
                        n_cx    = i_cell_x;
                        n_cy    = i_cell_y;
                        n_cz    = i_cell_z;
                        n_state = H_HMUL;
                    end
                end
            end
            H_CMUL: begin
                n_prod  = mul_p;
                n_neg   = pos_sel[POS_W-1];
                n_state = H_CSAT;
            end
            H_CSAT: begin
                case (r_axis)
                    2'd0:    n_cx = cell_sat;
                    2'd1:    n_cy = cell_sat;
                    default: n_cz = cell_sat;
                endcase
                if (r_axis == 2'd2) begin
                    n_axis  = 2'd0;
                    n_state = H_HMUL;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = H_CMUL;
                end
            end
            H_HMUL: begin
                n_prod  = mul_p;
                n_state = H_RSET;
            end
            H_RSET: begin
                n_neg   = prod_lo[31];
                n_mag   = prod_lo[31] ? (~prod_lo + 32'd1) : prod_lo;
                n_rem   = '0;
                n_bit   = 5'd31;
                n_state = H_REM;
            end
            H_REM: begin
                n_rem = rem_t[REM_W-1:0];
                n_mag = {r_mag[30:0], 1'b0};
                n_bit = r_bit - 5'd1;
                if (r_bit == 5'd0) begin
                    n_state = H_ACC;
                end
            end
            H_ACC: begin
                n_acc = r_acc + term;
                if (r_axis == 2'd2) begin
                    n_state = H_FOLD;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = H_HMUL;
                end
            end
            H_FOLD: begin
                // bring the sum into [0, n)
                if (r_acc < 0) begin
                    n_acc = r_acc + mod_s;
                end else if (r_acc >= mod_s) begin
                    n_acc = r_acc - mod_s;
                end else begin
                    n_done  = 1'b1;
                    n_state = H_IDLE;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_axis <= n_axis;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_bit  <= n_bit;
        r_rem  <= n_rem;
        r_acc  <= n_acc;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
    end

    assign acc_ext  = 32'(r_acc);
    assign o_bucket = acc_ext[IW-1:0];
    assign o_done   = r_done;
    assign o_cell_x = r_cx;
    assign o_cell_y = r_cy;
    assign o_cell_z = r_cz;

endmodule

@@ tb/spatial_hash_bucket_table_top_tb.sv @@
// Self-checking bench for spatial_hash_bucket_table_top: a bucket table model
// predicts every result of each accepted command. Depends on shbt_pkg and the RTL.
module spatial_hash_bucket_table_top_tb;
    import shbt_pkg::*;

    localparam int NBKT   = 1024;
    localparam int DEPTH  = 8;
    localparam int WD_MAX = 20000;

    typedef struct {
        logic [1:0]         op;
        logic [ID_W-1:0]    id;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] cx, cy, cz;
    } t_cmd;

    typedef struct {
        logic        status;
        logic [9:0]  bucket;
        logic        is_empty;
        logic        entry_valid;
        logic [15:0] entry_id;
        logic [15:0] ecx, ecy, ecz;
        logic [10:0] used_cells;
        logic        last;
    } t_res;

    typedef struct {
        logic [15:0] id, cx, cy, cz;
    } t_entry;

    // Bucket table model and pending result store
    class bucket_table_model;
        logic [31:0] inv_cell;
        logic [30:0] px_prime, py_prime, pz_prime;
        logic [10:0] ncells;
        int          fill [NBKT];
        bit          used [NBKT];
        int          used_list [NBKT];
        int          used_total;
        t_entry      entries [NBKT*DEPTH];
        t_res        pending [$];
        int          errors;

        function new();
            inv_cell   = RST_INV_CELL;
            px_prime   = RST_PRIME_X;
            py_prime   = RST_PRIME_Y;
            pz_prime   = RST_PRIME_Z;
            ncells     = RST_NUM_CELLS;
            used_total = 0;
            errors     = 0;
            foreach (fill[i]) begin
                fill[i] = 0;
                used[i] = 0;
            end
        endfunction

        function int cell_of(logic signed [31:0] p);
            longint          sp;
            longint unsigned mag, q;
            sp  = p;
            mag = (sp < 0) ? -sp : sp;
            q   = (mag * longint'(inv_cell)) >> 32;
            if (sp < 0) return (q > 32768) ? -32768 : -int'(q);
            return (q > 32767) ? 32767 : int'(q);
        endfunction

        function longint axis_rem(int c, logic [30:0] prime, longint n);
            logic [31:0] prod;
            prod = c * {1'b0, prime};
            return longint'($signed(prod)) % n;
        endfunction

        function int bucket_of(int x, int y, int z);
            longint n, v;
            n = (ncells == 0) ? 1 : ((ncells > NBKT) ? NBKT : ncells);
            v = axis_rem(x, px_prime, n) + axis_rem(y, py_prime, n) + axis_rem(z, pz_prime, n);
            v = v % n;
            if (v < 0) v += n;
            return int'(v);
        endfunction

        function void push(logic st, int b, logic emp, logic ev, t_entry e, logic lst);
            t_res r;
            r.status = st; r.bucket = 10'(b); r.is_empty = emp; r.entry_valid = ev;
            r.entry_id = e.id; r.ecx = e.cx; r.ecy = e.cy; r.ecz = e.cz;
            r.used_cells = 11'(used_total); r.last = lst;
            pending = {pending, r};
        endfunction

        function void note_command(t_cmd c);
            t_entry e, z;
            int     b;
            z = '{default: 0};
            case (c.op)
                OP_INSERT: begin
                    e.id = c.id;
                    e.cx = 16'(cell_of(c.px));
                    e.cy = 16'(cell_of(c.py));
                    e.cz = 16'(cell_of(c.pz));
                    b = bucket_of($signed(e.cx), $signed(e.cy), $signed(e.cz));
                    if (fill[b] >= DEPTH) begin
                        push(1'b1, b, 1'b0, 1'b0, z, 1'b1);
                    end else begin
                        entries[b*DEPTH + fill[b]] = e;
                        fill[b]++;
                        if (!used[b]) begin
                            used[b] = 1;
                            used_list[used_total++] = b;
                        end
                        push(1'b0, b, 1'b0, 1'b1, e, 1'b1);
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < used_total; i++) begin
                        fill[used_list[i]] = 0;
                        used[used_list[i]] = 0;
                    end
                    used_total = 0;
                    push(1'b0, 0, 1'b0, 1'b0, z, 1'b1);
                end
                default: begin
                    b = bucket_of(c.cx, c.cy, c.cz);
                    if (c.op == OP_QUERY || fill[b] == 0)
                        push(1'b0, b, fill[b] == 0, 1'b0, z, 1'b1);
                    else
                        for (int i = 0; i < fill[b]; i++)
                            push(1'b0, b, 1'b0, 1'b1, entries[b*DEPTH + i], i + 1 == fill[b]);
                end
            endcase
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_res a);
            t_res e;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("status", e.status, a.status);
            cmp("bucket", e.bucket, a.bucket);
            cmp("is_empty", e.is_empty, a.is_empty);
            cmp("entry_valid", e.entry_valid, a.entry_valid);
            cmp("entry_id", e.entry_id, a.entry_id);
            cmp("entry_cell_x", e.ecx, a.ecx);
            cmp("entry_cell_y", e.ecy, a.ecy);
            cmp("entry_cell_z", e.ecz, a.ecz);
            cmp("used_cells", e.used_cells, a.used_cells);
            cmp("last", e.last, a.last);
        endfunction
    endclass

    logic                     i_clk, i_rst_n, start, busy;
    logic [1:0]               i_opcode;
    logic [ID_W-1:0]          i_body_id;
    logic signed [POS_W-1:0]  i_pos_x, i_pos_y, i_pos_z;
    logic signed [CELL_W-1:0] i_cell_x, i_cell_y, i_cell_z;
    logic                     o_valid, o_status, o_is_empty, o_entry_valid, o_last;
    logic [BKT_OUT_W-1:0]     o_bucket;
    logic [ID_W-1:0]          o_entry_id;
    logic signed [CELL_W-1:0] o_entry_cell_x, o_entry_cell_y, o_entry_cell_z;
    logic [USED_OUT_W-1:0]    o_used_cells;
    logic                     psel, penable, pwrite, pready;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata, prdata;

    bucket_table_model table_model;
    t_cmd              cell_hist [$];
    int                idle_cycles;

    spatial_hash_bucket_table_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Result transfers
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && o_valid) begin
            r = '{o_status, o_bucket, o_is_empty, o_entry_valid, o_entry_id, o_entry_cell_x,
                  o_entry_cell_y, o_entry_cell_z, o_used_cells, o_last};
            table_model.check_result(r);
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (table_model.pending.size() != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            REG_INV_CELL:  table_model.inv_cell = val;
            REG_PRIME_X:   table_model.px_prime = val[30:0];
            REG_PRIME_Y:   table_model.py_prime = val[30:0];
            REG_PRIME_Z:   table_model.pz_prime = val[30:0];
            REG_NUM_CELLS: table_model.ncells   = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] inv, logic [30:0] ax, logic [30:0] ay,
                              logic [30:0] az, logic [10:0] n);
        wait_idle();
        write_reg(REG_INV_CELL, inv);
        write_reg(REG_PRIME_X, {1'b0, ax});
        write_reg(REG_PRIME_Y, {1'b0, ay});
        write_reg(REG_PRIME_Z, {1'b0, az});
        write_reg(REG_NUM_CELLS, 32'(n));
    endtask

    // One command transfer, after a random gap
    task automatic send(t_cmd c);
        int gap;
        t_cmd h;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode = c.op; i_body_id = c.id;
        i_pos_x = c.px; i_pos_y = c.py; i_pos_z = c.pz;
        i_cell_x = c.cx; i_cell_y = c.cy; i_cell_z = c.cz;
        start = 1;
        do @(posedge i_clk); while (busy);
        table_model.note_command(c);
        if (c.op == OP_INSERT) begin
            h.cx = 16'(table_model.cell_of(c.px));
            h.cy = 16'(table_model.cell_of(c.py));
            h.cz = 16'(table_model.cell_of(c.pz));
            cell_hist = {cell_hist, h};
            if (cell_hist.size() > 24) void'(cell_hist.pop_front());
        end
        @(negedge i_clk);
        start = 0;
    endtask

    function automatic t_cmd mk(logic [1:0] op, logic [15:0] id, logic [31:0] x,
                                logic [31:0] y, logic [31:0] z, logic [15:0] a,
                                logic [15:0] b, logic [15:0] c);
        t_cmd m;
        m.op = op; m.id = id; m.px = x; m.py = y; m.pz = z;
        m.cx = a; m.cy = b; m.cz = c;
        return m;
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0, 1:    return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
            2:       return $urandom;
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd m;
        int   r, k;
        r = $urandom_range(0, 99);
        m = mk(OP_INSERT, 16'($urandom), rand_pos(), rand_pos(), rand_pos(),
               16'($urandom), 16'($urandom), 16'($urandom));
        if (r >= 97) m.op = OP_CLEAR;
        else if (r >= 70) m.op = OP_READ;
        else if (r >= 55) m.op = OP_QUERY;
        if ((m.op == OP_READ || m.op == OP_QUERY) && cell_hist.size() > 0
            && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, cell_hist.size() - 1);
            m.cx = cell_hist[k].cx; m.cy = cell_hist[k].cy; m.cz = cell_hist[k].cz;
        end
        return m;
    endfunction

    initial begin
        table_model = new();
        i_rst_n = 0; start = 0;
        i_opcode = OP_INSERT; i_body_id = 0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0;
        i_cell_x = 0; i_cell_y = 0; i_cell_z = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extreme positions, full bucket, read, query, clear
        set_config(RST_INV_CELL, RST_PRIME_X, RST_PRIME_Y, RST_PRIME_Z, RST_NUM_CELLS);
        send(mk(OP_INSERT, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0));
        send(mk(OP_INSERT, 16'h0000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
        send(mk(OP_INSERT, 16'h1234, 0, 0, 0, 0, 0, 0));
        send(mk(OP_QUERY, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 0));
        send(mk(OP_READ, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send(mk(OP_READ, 0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000));
        for (int i = 0; i < 9; i++)
            send(mk(OP_INSERT, 16'(100 + i), 3 << 16, -(2 << 16), 5 << 16, 0, 0, 0));
        send(mk(OP_READ, 0, 0, 0, 0, 16'd3, -16'sd2, 16'd5));
        send(mk(OP_QUERY, 0, 0, 0, 0, 16'd3, -16'sd2, 16'd5));
        send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_READ, 0, 0, 0, 0, 16'd3, -16'sd2, 16'd5));
        send(mk(OP_QUERY, 0, 0, 0, 0, 16'd3, -16'sd2, 16'd5));

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(32'hFFFFFFFF, 31'h7FFFFFFF, 31'd0, 31'd1, 11'd1);
                1: set_config(32'd0, 31'($urandom), 31'($urandom), 31'($urandom), 11'd0);
                2: set_config(32'd1, 31'($urandom), 31'($urandom), 31'($urandom), 11'h7FF);
                3: set_config($urandom_range(1 << 12, 1 << 18), 31'($urandom),
                              31'($urandom), 31'($urandom), 11'($urandom_range(1, 8)));
                4: set_config(RST_INV_CELL, RST_PRIME_X, RST_PRIME_Y, RST_PRIME_Z, 11'd1024);
                default: set_config($urandom_range(1 << 14, 1 << 17), 31'($urandom),
                                    31'($urandom), 31'($urandom),
                                    ($urandom_range(0, 1) == 1) ?
                                    11'($urandom_range(1, 16)) : 11'd1024);
            endcase
            cell_hist.delete();
            for (int i = 0; i < 50; i++) send(rand_cmd());
        end
        start = 0;

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (table_model.errors == 0 && table_model.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
